@@ rtl/sktl_pkg.sv @@
// sktl_pkg: shared types and constants for the sorted top-k list block.
// Holds the item layouts, the entry type and the default capacity.
// No dependencies.
package sktl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int SCORE_W      = 16;
  localparam int TAG_W        = 16;
  localparam int RANK_W       = 5;

  // opcode codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // one stored entry
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;
  } entry_t;

  // input item
  typedef struct packed {
    logic                      opcode;
    logic signed [SCORE_W-1:0] new_score;
    logic        [TAG_W-1:0]   new_tag;
  } req_item_t;

  // result item
  typedef struct packed {
    logic        [RANK_W-1:0]  rank;
    logic signed [SCORE_W-1:0] entry_score;
    logic        [TAG_W-1:0]   entry_tag;
    logic                      entry_valid;
    logic                      last;
  } rsp_item_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic   ins_start; // insert item accepted this cycle
    logic   ins_en;    // insert accepted and entry not dropped
    logic   rot_en;    // rotate the list one place towards cell 0
    entry_t cand;      // entry being inserted
  } cell_ctrl_t;

endpackage

@@ rtl/sktl_chan_if.sv @@
// sktl_chan_if: valid/ready channel carrying one item of type T.
// Used for both the request and the result channel; no dependencies.
interface sktl_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sktl_cell.sv @@
// sktl_cell: one slot of the sorted chain, with its compare-and-shift logic.
// Depends on sktl_pkg.
module sktl_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 5
) (
  input  logic                clk,
  input  sktl_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    fill,
  input  logic                prev_keep,
  input  sktl_pkg::entry_t    left,
  input  sktl_pkg::entry_t    right,
  input  sktl_pkg::entry_t    wrap,
  output sktl_pkg::entry_t    entry,
  output logic                keep,
  output logic                here
);
  import sktl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic occupied;
  logic is_tail;
  logic ins_here;

  // slot decisions against the candidate and the fill count
  assign occupied = MY_IDX < fill;
  assign is_tail  = MY_IDX == (fill - 1'b1);
  assign keep     = occupied && ($signed(entry.score) >= $signed(ctrl.cand.score));
  assign ins_here = prev_keep && !keep;

  // slot storage: hold, take the new entry, shift right, or rotate left
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (ins_here) begin
        entry <= ctrl.cand;
      end else if (!keep) begin
        entry <= left;
      end
    end else if (ctrl.rot_en) begin
      entry <= is_tail ? wrap : right;
    end
    if (ctrl.ins_start) begin
      here <= ins_here;
    end
  end

endmodule

@@ rtl/sorted_top_k_list_core.sv @@
// sorted_top_k_list_core: bounded list of CAPACITY entries in descending score order.
// Insert: the compare-and-shift chain places the entry in the accept cycle; the rank is
//   encoded in S_INS, and no new request is taken until the result has been loaded.
// Read: one result per cycle for n entries (one result for an empty list) while the result
//   register is free; the chain rotates one place per result and is restored at the end.
// Reset (rst, synchronous, active high) empties the list; slot contents are not cleared.
module sorted_top_k_list_core #(
  parameter int CAPACITY = sktl_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  sktl_chan_if.sink   req,
  sktl_chan_if.source rsp
);
  import sktl_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_RD} state_t;

  state_t              state;
  logic [IDX_W-1:0]    fill;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    rank_enc;
  entry_t              evict;
  logic                evict_v;
  logic                dropped_q;
  rsp_item_t           out_q;
  logic                out_valid;

  cell_ctrl_t          ctrl;
  entry_t              cell_q  [CAPACITY];
  entry_t              left_d  [CAPACITY];
  entry_t              right_d [CAPACITY];
  logic [CAPACITY:0]   keep_chain;
  logic [CAPACITY-1:0] here_q;

  logic req_fire;
  logic is_ins;
  logic dropped;
  logic out_free;
  logic out_load;

  // handshake
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign is_ins    = req_fire && (req.data.opcode == OP_INSERT);
  assign out_free  = !out_valid || rsp.ready;
  assign out_load  = out_free && ((state == S_INS) || (state == S_RD));
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // broadcast controls
  assign dropped        = keep_chain[CAPACITY];
  assign last_idx       = fill - 1'b1;
  assign ctrl.ins_start = is_ins;
  assign ctrl.ins_en    = is_ins && !dropped;
  assign ctrl.rot_en    = (state == S_RD) && out_free && (fill != '0);
  assign ctrl.cand.score = req.data.new_score;
  assign ctrl.cand.tag   = req.data.new_tag;
  assign keep_chain[0]   = 1'b1;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_left_head
      assign left_d[i] = ctrl.cand;
    end else begin : g_left
      assign left_d[i] = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_right_tail
      assign right_d[i] = cell_q[0];
    end else begin : g_right
      assign right_d[i] = cell_q[i+1];
    end

    sktl_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .fill      (fill),
      .prev_keep (keep_chain[i]),
      .left      (left_d[i]),
      .right     (right_d[i]),
      .wrap      (cell_q[0]),
      .entry     (cell_q[i]),
      .keep      (keep_chain[i+1]),
      .here      (here_q[i])
    );
  end

  // one-hot insertion point to rank
  always_comb begin
    rank_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (here_q[i]) begin
        rank_enc = rank_enc | IDX_W'(i);
      end
    end
  end

  // sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fill      <= '0;
      rd_idx    <= '0;
    end else begin
      // result valid: set on a load, cleared once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.data.opcode == OP_INSERT) begin
              if (!dropped && (fill != IDX_W'(CAPACITY))) begin
                fill <= fill + 1'b1;
              end
              evict     <= cell_q[CAPACITY-1];
              evict_v   <= !dropped && (fill == IDX_W'(CAPACITY));
              dropped_q <= dropped;
              state     <= S_INS;
            end else begin
              rd_idx <= '0;
              state  <= S_RD;
            end
          end
        end
        S_INS: begin
          if (out_free) begin
            out_q.rank        <= dropped_q ? RANK_W'(CAPACITY) : RANK_W'(rank_enc);
            out_q.entry_score <= evict_v ? evict.score : '0;
            out_q.entry_tag   <= evict_v ? evict.tag : '0;
            out_q.entry_valid <= evict_v;
            out_q.last        <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_RD: begin
          if (out_free) begin
            if (fill == '0) begin
              // empty list: a single blank result
              out_q.rank        <= '0;
              out_q.entry_score <= '0;
              out_q.entry_tag   <= '0;
              out_q.entry_valid <= 1'b0;
              out_q.last        <= 1'b1;
              state             <= S_IDLE;
            end else begin
              out_q.rank        <= RANK_W'(rd_idx);
              out_q.entry_score <= cell_q[0].score;
              out_q.entry_tag   <= cell_q[0].tag;
              out_q.entry_valid <= 1'b1;
              out_q.last        <= (rd_idx == last_idx);
              rd_idx            <= rd_idx + 1'b1;
              if (rd_idx == last_idx) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // fill count stays within capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= IDX_W'(CAPACITY))
    else $error("fill count above capacity");

  // at most one insertion point while the rank is encoded
  a_one_point: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> $onehot0(here_q))
    else $error("more than one insertion point");

  // a placed entry into a list with room grows the fill count by one
  a_fill_grow: assert property (@(posedge clk) disable iff (rst)
    (is_ins && !dropped && (fill != IDX_W'(CAPACITY))) |=> (fill == $past(fill) + 1'b1))
    else $error("fill count did not grow on insert");

  // a read never runs past the last entry
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD && fill != '0) |-> (rd_idx < fill))
    else $error("read index past fill count");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for sorted_top_k_list_core; a scoreboard class keeps a
// sorted copy of the list and predicts every result. Depends on sktl_pkg and sktl_chan_if.
module tb_top;
  import sktl_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 460;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 8;

  // Scoreboard: sorted copy of the list and the queue of results still to come
  class topk_scoreboard;
    entry_t    ranked_list[$];
    rsp_item_t pending_results[$];
    int        errors;
    int        n_inserts;
    int        n_reads;
    int        n_drops;
    int        n_evicts;
    int        n_results;

    // Work out the results of one accepted item and update the list copy
    function void record_request(req_item_t it);
      rsp_item_t r;
      entry_t    e;
      int        pos;
      r = '0;
      if (it.opcode == OP_READ) begin
        n_reads++;
        if (ranked_list.size() == 0) begin
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < ranked_list.size(); i++) begin
            r.rank        = i[RANK_W-1:0];
            r.entry_score = ranked_list[i].score;
            r.entry_tag   = ranked_list[i].tag;
            r.entry_valid = 1'b1;
            r.last        = (i == ranked_list.size() - 1);
            pending_results.push_back(r);
          end
        end
      end else begin
        n_inserts++;
        // equal scores keep arrival order: go past every score >= the new one
        pos = 0;
        while (pos < ranked_list.size() &&
               $signed(ranked_list[pos].score) >= $signed(it.new_score))
          pos++;
        r.last = 1'b1;
        r.rank = pos[RANK_W-1:0];
        if (pos >= CAP) begin
          n_drops++;
        end else begin
          if (ranked_list.size() == CAP) begin
            e             = ranked_list.pop_back();
            r.entry_score = e.score;
            r.entry_tag   = e.tag;
            r.entry_valid = 1'b1;
            n_evicts++;
          end
          e.score = it.new_score;
          e.tag   = it.new_tag;
          ranked_list.insert(pos, e);
        end
        pending_results.push_back(r);
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(rsp_item_t got);
      rsp_item_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rank=%0d score=%0d tag=%h valid=%b last=%b",
                 $time, got.rank, $signed(got.entry_score), got.entry_tag,
                 got.entry_valid, got.last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.rank !== want.rank) begin
        $display("%0t: rank mismatch: expected %0d, got %0d", $time, want.rank, got.rank);
        errors++;
      end
      if (got.entry_score !== want.entry_score) begin
        $display("%0t: entry_score mismatch: expected %0d, got %0d", $time,
                 $signed(want.entry_score), $signed(got.entry_score));
        errors++;
      end
      if (got.entry_tag !== want.entry_tag) begin
        $display("%0t: entry_tag mismatch: expected %h, got %h", $time,
                 want.entry_tag, got.entry_tag);
        errors++;
      end
      if (got.entry_valid !== want.entry_valid) begin
        $display("%0t: entry_valid mismatch: expected %b, got %b", $time,
                 want.entry_valid, got.entry_valid);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %b, got %b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    // A score already in the list, to provoke ties and inside placements
    function logic signed [SCORE_W-1:0] existing_score();
      if (ranked_list.size() == 0)
        return SCORE_W'($urandom);
      return ranked_list[$urandom_range(0, ranked_list.size() - 1)].score;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sktl_chan_if #(.T(req_item_t)) req_if ();
  sktl_chan_if #(.T(rsp_item_t)) rsp_if ();

  topk_scoreboard board = new();

  int send_quiet  = 0;
  int recv_quiet  = 0;
  int idle_cycles = 0;

  sorted_top_k_list_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #6 clk = ~clk;

  // Gap before the next item: 0..15, with runs of back-to-back items
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_item(input req_item_t it);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
    board.record_request(it);
  endtask

  task automatic send_insert(input logic signed [SCORE_W-1:0] score,
                             input logic [TAG_W-1:0] tag);
    req_item_t it;
    it.opcode    = OP_INSERT;
    it.new_score = score;
    it.new_tag   = tag;
    send_item(it);
  endtask

  // score and tag are don't-care on a read, so fill them with noise
  task automatic send_read();
    req_item_t it;
    it.opcode    = OP_READ;
    it.new_score = SCORE_W'($urandom);
    it.new_tag   = TAG_W'($urandom);
    send_item(it);
  endtask

  // Result side: random stalls, check every accepted item
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(recv_quiet);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      board.check_result(rsp_if.data);
    end
  end

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("** sorted_top_k_list_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int                        pick;
    logic signed [SCORE_W-1:0] base;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, extremes, ties, fill up, drop, evictions, full read
    send_read();
    send_insert(16'sh7FFF, 16'hFFFF);
    send_insert(16'sh8000, 16'h0000);
    send_insert(16'sd0, 16'h0001);
    send_insert(16'sd0, 16'h0002);
    send_read();
    send_insert(16'sd1000, 16'h5555);
    send_insert(-16'sd1, 16'hAAAA);
    send_insert(-16'sd1, 16'h0003);
    send_insert(16'sd200, 16'h0004);
    send_insert(16'sh7FFF, 16'h0005);
    send_insert(-16'sd32767, 16'h0006);
    send_insert(16'sd5, 16'h0007);
    send_insert(16'sd5, 16'h0008);
    send_insert(16'sd300, 16'h0009);
    send_insert(-16'sd200, 16'h000A);
    send_insert(16'sd7000, 16'h000B);
    send_insert(16'sd1, 16'h000C);
    // list now full: a tie with the lowest score ranks last and is dropped
    send_insert(16'sh8000, 16'h1234);
    // ranks just above the end: evicts the lowest
    send_insert(-16'sd32767, 16'h4321);
    // ties at the top, placed after the two existing maxima
    send_insert(16'sh7FFF, 16'hABCD);
    send_read();
    send_insert(16'sh8000, 16'hFFFF);
    send_read();

    // random: mostly scores near the list contents, plus noise and extremes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_read();
      end else if (pick < 40) begin
        send_insert(SCORE_W'($urandom), TAG_W'($urandom));
      end else if (pick < 65) begin
        send_insert(board.existing_score(), TAG_W'($urandom));
      end else if (pick < 90) begin
        base = board.existing_score();
        send_insert(base + SCORE_W'($urandom_range(0, 6)) - SCORE_W'(3), TAG_W'($urandom));
      end else if (pick < 95) begin
        send_insert($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, TAG_W'($urandom));
      end else begin
        send_insert(16'sh8000 + SCORE_W'($urandom_range(0, 20)), TAG_W'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    // drain
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d inserts (%0d dropped, %0d evicting) and %0d read-outs,",
             board.n_inserts, board.n_drops, board.n_evicts, board.n_reads);
    $display("with %0d result items checked and %0d mismatches.",
             board.n_results, board.errors);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("** sorted_top_k_list_core: PASSED **");
    end else begin
      $display("** sorted_top_k_list_core: FAILED **");
    end
    $finish;
  end

endmodule
